// ===== rtl/cafl_pkg.sv =====
package cafl_pkg;

  // Pool geometry (ENTRY_BYTES must be a power of two)
  localparam int POOL_DEPTH  = 64;
  localparam int ENTRY_BYTES = 64;
  localparam int MIN_ENTRIES = 2;
  localparam int MARGIN_RST  = 10;

  localparam int ADDR_W      = 32;
  localparam int CNT_W       = 7;
  localparam int MARGIN_W    = 6;
  localparam int IDX_W       = $clog2(POOL_DEPTH);
  localparam int LINK_W      = $clog2(POOL_DEPTH + 1);
  localparam int ENTRY_SHIFT = $clog2(ENTRY_BYTES);
  localparam int SLOT_W      = ADDR_W - ENTRY_SHIFT;

  localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(POOL_DEPTH);

  // Configuration register indexes
  localparam logic [1:0] REG_POOL_BASE   = 2'd0;
  localparam logic [1:0] REG_ENTRY_COUNT = 2'd1;
  localparam logic [1:0] REG_LOW_MARGIN  = 2'd2;

  typedef enum logic [1:0] {
    CMD_INIT  = 2'd0,
    CMD_ALLOC = 2'd1,
    CMD_FREE  = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    STS_OK       = 2'd0,
    STS_DEPLETED = 2'd1,
    STS_BAD_CFG  = 2'd2,
    STS_BAD_ADDR = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_POP,
    S_FILL
  } state_e;

  typedef struct packed {
    logic [ADDR_W-1:0]   pool_base;
    logic [CNT_W-1:0]    entry_count;
    logic [MARGIN_W-1:0] low_margin;
  } cfg_t;

  // Controller to datapath
  typedef struct packed {
    logic finish_imm;
    logic start_read;
    logic start_fill;
    logic pop;
    logic fill;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic is_init;
    logic is_alloc;
    logic init_ok;
    logic alloc_ok;
    logic fill_last;
  } dp_sts_t;

endpackage

// ===== rtl/context_area_free_list_allocator.sv =====
// Free, command 3 and every rejected command register their result beat on accept;
// alloc registers a link-memory read, then pops; init sweeps entry_count entries.
// Throughput: one free per cycle while idle; alloc and init hold busy until done.
// The init sweep writes one link-memory entry per cycle; the receiver cannot stall.
// Reset clears the list head to null, the counters and flags, and loads the config
// defaults; the link memory is not cleared and needs no clearing pass.
module context_area_free_list_allocator (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    command_i,
  input  logic [cafl_pkg::ADDR_W-1:0]   entry_address_i,
  output logic                          done_o,
  output logic [1:0]                    status_o,
  output logic [cafl_pkg::ADDR_W-1:0]   alloc_address_o,
  output logic [cafl_pkg::CNT_W-1:0]    free_entries_o,
  output logic                          low_warning_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [3:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  cafl_pkg::cfg_t    cfg;
  cafl_pkg::dp_cmd_t cmd;
  cafl_pkg::dp_sts_t sts;

  // Configuration registers
  cafl_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Command sequencer
  cafl_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .sts_i  (sts),
    .cmd_o  (cmd),
    .busy   (busy)
  );

  // List state and link memory
  cafl_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg),
    .cmd_i           (cmd),
    .command_i       (command_i),
    .entry_address_i (entry_address_i),
    .sts_o           (sts),
    .done_o          (done_o),
    .status_o        (status_o),
    .alloc_address_o (alloc_address_o),
    .free_entries_o  (free_entries_o),
    .low_warning_o   (low_warning_o)
  );

endmodule

// ===== rtl/cafl_regs.sv =====
module cafl_regs (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  output cafl_pkg::cfg_t      cfg_o
);

  logic [cafl_pkg::ADDR_W-1:0]   pool_base_q;
  logic [cafl_pkg::CNT_W-1:0]    entry_count_q;
  logic [cafl_pkg::MARGIN_W-1:0] low_margin_q;
  logic                          wr_en;
  logic [1:0]                    reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel & penable & pwrite & pready;

  // Write a register on the access beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pool_base_q   <= '0;
      entry_count_q <= cafl_pkg::CNT_W'(cafl_pkg::POOL_DEPTH);
      low_margin_q  <= cafl_pkg::MARGIN_W'(cafl_pkg::MARGIN_RST);
    end else if (wr_en) begin
      case (reg_idx)
        cafl_pkg::REG_POOL_BASE:   pool_base_q   <= pwdata;
        cafl_pkg::REG_ENTRY_COUNT: entry_count_q <= pwdata[cafl_pkg::CNT_W-1:0];
        cafl_pkg::REG_LOW_MARGIN:  low_margin_q  <= pwdata[cafl_pkg::MARGIN_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back the addressed register
  always_comb begin
    case (reg_idx)
      cafl_pkg::REG_POOL_BASE:   prdata = pool_base_q;
      cafl_pkg::REG_ENTRY_COUNT: prdata = 32'(entry_count_q);
      cafl_pkg::REG_LOW_MARGIN:  prdata = 32'(low_margin_q);
      default:                   prdata = '0;
    endcase
  end

  assign cfg_o.pool_base   = pool_base_q;
  assign cfg_o.entry_count = entry_count_q;
  assign cfg_o.low_margin  = low_margin_q;

endmodule

// ===== rtl/cafl_ctrl.sv =====
module cafl_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  input  cafl_pkg::dp_sts_t   sts_i,
  output cafl_pkg::dp_cmd_t   cmd_o,
  output logic                busy
);

  cafl_pkg::state_e state_q, state_d;
  logic             accept;

  assign accept = start & (state_q == cafl_pkg::S_IDLE);

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      cafl_pkg::S_IDLE: begin
        if (accept && sts_i.is_alloc && sts_i.alloc_ok) begin
          state_d = cafl_pkg::S_POP;
        end else if (accept && sts_i.is_init && sts_i.init_ok) begin
          state_d = cafl_pkg::S_FILL;
        end
      end
      cafl_pkg::S_POP: begin
        state_d = cafl_pkg::S_IDLE;
      end
      cafl_pkg::S_FILL: begin
        if (sts_i.fill_last) begin
          state_d = cafl_pkg::S_IDLE;
        end
      end
      default: state_d = cafl_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= cafl_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Datapath commands
  always_comb begin
    cmd_o = '0;
    busy  = 1'b1;
    case (state_q)
      cafl_pkg::S_IDLE: begin
        busy             = 1'b0;
        cmd_o.start_read = accept & sts_i.is_alloc & sts_i.alloc_ok;
        cmd_o.start_fill = accept & sts_i.is_init & sts_i.init_ok;
        cmd_o.finish_imm = accept & ~(sts_i.is_alloc & sts_i.alloc_ok)
                                  & ~(sts_i.is_init & sts_i.init_ok);
      end
      cafl_pkg::S_POP:  cmd_o.pop  = 1'b1;
      cafl_pkg::S_FILL: cmd_o.fill = 1'b1;
      default: ;
    endcase
  end

  // The pop state is always followed directly by idle
  a_pop_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == cafl_pkg::S_POP) |=> (state_q == cafl_pkg::S_IDLE))
    else $error("pop state lasted more than one cycle");

  // At most one command is issued per cycle
  a_cmd_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.finish_imm, cmd_o.start_read, cmd_o.start_fill, cmd_o.pop, cmd_o.fill}))
    else $error("overlapping datapath commands");

  // A read is only started for an allocation that can succeed
  a_read_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.start_read |-> (sts_i.is_alloc && sts_i.alloc_ok))
    else $error("link read started without a valid head");

endmodule

// ===== rtl/cafl_dp.sv =====
module cafl_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  cafl_pkg::cfg_t                cfg_i,
  input  cafl_pkg::dp_cmd_t             cmd_i,
  input  logic [1:0]                    command_i,
  input  logic [cafl_pkg::ADDR_W-1:0]   entry_address_i,
  output cafl_pkg::dp_sts_t             sts_o,
  output logic                          done_o,
  output logic [1:0]                    status_o,
  output logic [cafl_pkg::ADDR_W-1:0]   alloc_address_o,
  output logic [cafl_pkg::CNT_W-1:0]    free_entries_o,
  output logic                          low_warning_o
);

  // Link memory, undefined until written
  logic [cafl_pkg::LINK_W-1:0] link_mem [cafl_pkg::POOL_DEPTH];
  logic [cafl_pkg::LINK_W-1:0] rd_q;

  // List state
  logic [cafl_pkg::LINK_W-1:0] head_q;
  logic [cafl_pkg::LINK_W-1:0] limit_q;
  logic [cafl_pkg::CNT_W-1:0]  cnt_q;
  logic [cafl_pkg::CNT_W-1:0]  active_q;
  logic                        low_q;
  logic                        ready_q;
  logic [cafl_pkg::IDX_W-1:0]  fill_q;

  // Result registers
  logic                        done_q;
  cafl_pkg::status_e           status_q;
  logic [cafl_pkg::ADDR_W-1:0] addr_q;

  cafl_pkg::cmd_e              op;
  logic                        base_aligned;
  logic                        cnt_ok;
  logic [cafl_pkg::ADDR_W:0]   pool_top;
  logic                        end_ok;
  logic [cafl_pkg::ADDR_W-1:0] offset;
  logic [cafl_pkg::SLOT_W-1:0] slot;
  logic                        addr_zero;
  logic                        addr_below;
  logic                        addr_misaligned;
  logic                        slot_ok;
  logic                        push;
  cafl_pkg::status_e           imm_status;
  logic                        mem_we;
  logic [cafl_pkg::IDX_W-1:0]  mem_waddr;
  logic [cafl_pkg::LINK_W-1:0] mem_wdata;
  logic [cafl_pkg::LINK_W-1:0] nxt;
  logic [cafl_pkg::LINK_W-1:0] limit_new;
  logic [cafl_pkg::ADDR_W-1:0] head_addr;

  assign op = cafl_pkg::cmd_e'(command_i);

  // Init checks: alignment, count range, pool end within address space
  assign base_aligned = (cfg_i.pool_base[cafl_pkg::ENTRY_SHIFT-1:0] == '0);
  assign cnt_ok   = (cfg_i.entry_count >= cafl_pkg::CNT_W'(cafl_pkg::MIN_ENTRIES)) &&
                    (cfg_i.entry_count <= cafl_pkg::CNT_W'(cafl_pkg::POOL_DEPTH));
  assign pool_top = {1'b0, cfg_i.pool_base} +
                    ((cafl_pkg::ADDR_W+1)'(cfg_i.entry_count) << cafl_pkg::ENTRY_SHIFT);
  assign end_ok   = (pool_top <= ((cafl_pkg::ADDR_W+1)'(1) << cafl_pkg::ADDR_W));

  // Free checks: map the byte address to a pool slot
  assign offset          = entry_address_i - cfg_i.pool_base;
  assign slot            = offset[cafl_pkg::ADDR_W-1:cafl_pkg::ENTRY_SHIFT];
  assign addr_zero       = (entry_address_i == '0);
  assign addr_below      = (entry_address_i < cfg_i.pool_base);
  assign addr_misaligned = (offset[cafl_pkg::ENTRY_SHIFT-1:0] != '0);
  assign slot_ok         = (slot < cafl_pkg::SLOT_W'(active_q));

  assign sts_o.is_init   = (op == cafl_pkg::CMD_INIT);
  assign sts_o.is_alloc  = (op == cafl_pkg::CMD_ALLOC);
  assign sts_o.init_ok   = base_aligned & cnt_ok & end_ok;
  assign sts_o.alloc_ok  = ready_q & (head_q < cafl_pkg::NULL_LINK);
  assign sts_o.fill_last = (cafl_pkg::CNT_W'(fill_q) + cafl_pkg::CNT_W'(1)
                            == cfg_i.entry_count);

  // Status of commands that finish on the accept beat
  always_comb begin
    imm_status = cafl_pkg::STS_OK;
    push       = 1'b0;
    case (op)
      cafl_pkg::CMD_INIT:  imm_status = cafl_pkg::STS_BAD_CFG;
      cafl_pkg::CMD_ALLOC: imm_status = cafl_pkg::STS_DEPLETED;
      cafl_pkg::CMD_FREE: begin
        if (addr_zero) begin
          imm_status = cafl_pkg::STS_OK;
        end else if (!ready_q) begin
          imm_status = cafl_pkg::STS_DEPLETED;
        end else if (addr_below || addr_misaligned || !slot_ok) begin
          imm_status = cafl_pkg::STS_BAD_ADDR;
        end else begin
          imm_status = cafl_pkg::STS_OK;
          push       = cmd_i.finish_imm;
        end
      end
      default: imm_status = cafl_pkg::STS_OK;
    endcase
  end

  // Link memory write: init sweep or push of a freed entry
  always_comb begin
    mem_we    = cmd_i.fill | push;
    mem_waddr = slot[cafl_pkg::IDX_W-1:0];
    mem_wdata = head_q;
    if (cmd_i.fill) begin
      mem_waddr = fill_q;
      mem_wdata = sts_o.fill_last ? cafl_pkg::NULL_LINK
                                  : cafl_pkg::LINK_W'(fill_q) + cafl_pkg::LINK_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      link_mem[mem_waddr] <= mem_wdata;
    end
    if (cmd_i.start_read) begin
      rd_q <= link_mem[head_q[cafl_pkg::IDX_W-1:0]];
    end
  end

  // Clamp a corrupt link to null
  assign nxt       = (rd_q > cafl_pkg::NULL_LINK) ? cafl_pkg::NULL_LINK : rd_q;
  assign limit_new = (cfg_i.entry_count > cafl_pkg::CNT_W'(cfg_i.low_margin))
                   ? cafl_pkg::LINK_W'(cfg_i.entry_count) - cafl_pkg::LINK_W'(cfg_i.low_margin)
                   : '0;
  assign head_addr = cfg_i.pool_base +
                     (cafl_pkg::ADDR_W'(head_q[cafl_pkg::IDX_W-1:0]) << cafl_pkg::ENTRY_SHIFT);

  // Advance the init sweep index
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
    end else if (cmd_i.start_fill) begin
      fill_q <= '0;
    end else if (cmd_i.fill) begin
      fill_q <= fill_q + cafl_pkg::IDX_W'(1);
    end
  end

  // Update list state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q   <= cafl_pkg::NULL_LINK;
      limit_q  <= '0;
      cnt_q    <= '0;
      active_q <= '0;
      low_q    <= 1'b0;
      ready_q  <= 1'b0;
    end else if (push) begin
      head_q <= cafl_pkg::LINK_W'(slot[cafl_pkg::IDX_W-1:0]);
      if (cnt_q < active_q) begin
        cnt_q <= cnt_q + cafl_pkg::CNT_W'(1);
      end
    end else if (cmd_i.pop) begin
      head_q <= nxt;
      if (cnt_q != '0) begin
        cnt_q <= cnt_q - cafl_pkg::CNT_W'(1);
      end
      if ((nxt < cafl_pkg::NULL_LINK) && (nxt == limit_q)) begin
        low_q <= 1'b1;
      end
    end else if (cmd_i.fill && sts_o.fill_last) begin
      head_q   <= '0;
      limit_q  <= limit_new;
      cnt_q    <= cfg_i.entry_count;
      active_q <= cfg_i.entry_count;
      low_q    <= 1'b0;
      ready_q  <= 1'b1;
    end
  end

  // Hold the result beat for one cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= cmd_i.finish_imm | cmd_i.pop | (cmd_i.fill & sts_o.fill_last);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish_imm) begin
      status_q <= imm_status;
      addr_q   <= '0;
    end else if (cmd_i.pop) begin
      status_q <= cafl_pkg::STS_OK;
      addr_q   <= head_addr;
    end else if (cmd_i.fill && sts_o.fill_last) begin
      status_q <= cafl_pkg::STS_OK;
      addr_q   <= '0;
    end
  end

  assign done_o          = done_q;
  assign status_o        = status_q;
  assign alloc_address_o = addr_q;
  assign free_entries_o  = cnt_q;
  assign low_warning_o   = low_q;

  // Free count never exceeds the initialized pool size
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= active_q)
    else $error("free count above pool size");

  // Head is a valid entry or the null marker
  a_head_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_q <= cafl_pkg::NULL_LINK)
    else $error("head beyond null marker");

  // An uninitialized pool has an empty list
  a_not_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !ready_q |-> (head_q == cafl_pkg::NULL_LINK && cnt_q == '0))
    else $error("list state set before init");

  // A pop delivers its result on the next cycle
  a_pop_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.pop |=> done_q)
    else $error("pop without result beat");

endmodule

// ===== tb/sv/testbench.sv =====
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import cafl_pkg::*;

  localparam logic [1:0] CMD_UNUSED   = 2'd3;
  localparam int         RANDOM_ITEMS = 2000;
  localparam int         TAIL_ITEMS   = 300;

  typedef struct packed {
    logic [1:0]        status;
    logic [ADDR_W-1:0] addr;
    logic [CNT_W-1:0]  free_cnt;
    logic              low;
  } pool_reply_t;

  typedef struct packed {
    bit                  is_cfg;
    logic [ADDR_W-1:0]   base;
    logic [CNT_W-1:0]    count;
    logic [MARGIN_W-1:0] margin;
    logic [1:0]          cmd;
    logic [ADDR_W-1:0]   addr;
    bit                  typed;
    pool_reply_t         reply;
  } stim_row_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  logic [1:0]        command_i = CMD_INIT;
  logic [ADDR_W-1:0] entry_address_i = '0;
  logic              done_o;
  logic [1:0]        status_o;
  logic [ADDR_W-1:0] alloc_address_o;
  logic [CNT_W-1:0]  free_entries_o;
  logic              low_warning_o;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [3:0]        paddr = '0;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  logic              pready;

  // Predicted replies in order of acceptance
  pool_reply_t       pool_reply_q[$];
  stim_row_t         directed_rows[$];
  logic [ADDR_W-1:0] held_q[$];
  int                fail_count = 0;
  int                random_sent = 0;
  bit                idle_on = 1'b1;

  // Shadow of the allocator state and its registers
  logic [LINK_W-1:0] link_mem [POOL_DEPTH];
  int                head_idx = POOL_DEPTH;
  int                warn_entry = 0;
  int                free_cnt = 0;
  int                active_cnt = 0;
  bit                low_flag = 1'b0;
  bit                ready_flag = 1'b0;
  logic [ADDR_W-1:0] cfg_base = '0;
  int                cfg_count = POOL_DEPTH;
  int                cfg_margin = MARGIN_RST;

  context_area_free_list_allocator DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .command_i       (command_i),
    .entry_address_i (entry_address_i),
    .done_o          (done_o),
    .status_o        (status_o),
    .alloc_address_o (alloc_address_o),
    .free_entries_o  (free_entries_o),
    .low_warning_o   (low_warning_o),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  always #4ns clk_i = ~clk_i;

  initial begin
    #10ms;
    $display("TB_ERROR");
    $finish;
  end

  // Advance the shadow pool by one command and return its reply
  function automatic pool_reply_t compute_pool_reply(logic [1:0] cmd, logic [ADDR_W-1:0] addr);
    pool_reply_t r;
    logic [63:0] span_top;
    logic [ADDR_W-1:0] offset;
    int idx;
    int nxt;
    r = '0;
    r.status = STS_OK;
    case (cmd)
      CMD_INIT: begin
        span_top = {32'd0, cfg_base} + 64'(cfg_count * ENTRY_BYTES);
        if ((cfg_base % ENTRY_BYTES) != 0 || cfg_count < MIN_ENTRIES ||
            cfg_count > POOL_DEPTH || span_top > 64'h1_0000_0000) begin
          r.status = STS_BAD_CFG;
        end else begin
          for (int i = 0; i + 1 < cfg_count; i++) link_mem[i] = LINK_W'(i + 1);
          link_mem[cfg_count-1] = NULL_LINK;
          head_idx   = 0;
          warn_entry = (cfg_count > cfg_margin) ? cfg_count - cfg_margin : 0;
          free_cnt   = cfg_count;
          active_cnt = cfg_count;
          low_flag   = 1'b0;
          ready_flag = 1'b1;
        end
      end
      CMD_ALLOC: begin
        if (!ready_flag || head_idx >= POOL_DEPTH) begin
          r.status = STS_DEPLETED;
        end else begin
          r.addr = cfg_base + ADDR_W'(head_idx * ENTRY_BYTES);
          nxt = link_mem[head_idx];
          if (nxt > POOL_DEPTH) nxt = POOL_DEPTH;
          head_idx = nxt;
          if (free_cnt > 0) free_cnt--;
          if (head_idx < POOL_DEPTH && head_idx == warn_entry) low_flag = 1'b1;
        end
      end
      CMD_FREE: begin
        // Address zero means nothing to free
        if (addr != '0) begin
          if (!ready_flag) begin
            r.status = STS_DEPLETED;
          end else if (addr < cfg_base) begin
            r.status = STS_BAD_ADDR;
          end else begin
            offset = addr - cfg_base;
            idx = int'(offset / ENTRY_BYTES);
            if ((offset % ENTRY_BYTES) != 0 || idx >= active_cnt || idx >= POOL_DEPTH) begin
              r.status = STS_BAD_ADDR;
            end else begin
              link_mem[idx] = LINK_W'(head_idx);
              head_idx = idx;
              if (free_cnt < active_cnt) free_cnt++;
            end
          end
        end
      end
      default: ;
    endcase
    r.free_cnt = CNT_W'(free_cnt);
    r.low      = low_flag;
    return r;
  endfunction

  // Compare each result beat with the oldest prediction
  always @(posedge clk_i) begin : check_beat
    pool_reply_t want;
    if (rst_ni && done_o === 1'b1) begin
      if (pool_reply_q.size() == 0) begin
        $display("%0t: unexpected result beat, status %0d addr %h", $time, status_o,
                 alloc_address_o);
        fail_count++;
      end else begin
        want = pool_reply_q.pop_front();
        if (status_o !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status, status_o);
          fail_count++;
        end
        if (alloc_address_o !== want.addr) begin
          $display("%0t: alloc_address expected %h actual %h", $time, want.addr,
                   alloc_address_o);
          fail_count++;
        end
        if (free_entries_o !== want.free_cnt) begin
          $display("%0t: free_entries expected %0d actual %0d", $time, want.free_cnt,
                   free_entries_o);
          fail_count++;
        end
        if (low_warning_o !== want.low) begin
          $display("%0t: low_warning expected %0d actual %0d", $time, want.low, low_warning_o);
          fail_count++;
        end
      end
    end
  end

  task automatic row_cfg(input logic [ADDR_W-1:0] base, input int count, input int margin);
    stim_row_t row;
    row = '0;
    row.is_cfg = 1'b1;
    row.base   = base;
    row.count  = CNT_W'(count);
    row.margin = MARGIN_W'(margin);
    directed_rows.push_back(row);
  endtask

  task automatic row_cmd(input logic [1:0] cmd, input logic [ADDR_W-1:0] addr);
    stim_row_t row;
    row = '0;
    row.cmd  = cmd;
    row.addr = addr;
    directed_rows.push_back(row);
  endtask

  task automatic row_chk(input logic [1:0] cmd, input logic [ADDR_W-1:0] addr,
                         input status_e st, input logic [ADDR_W-1:0] a, input int f,
                         input bit l);
    stim_row_t row;
    row = '0;
    row.cmd   = cmd;
    row.addr  = addr;
    row.typed = 1'b1;
    row.reply = '{status: st, addr: a, free_cnt: CNT_W'(f), low: l};
    directed_rows.push_back(row);
  endtask

  // One APB transfer: setup phase, then access until pready
  task automatic apb_access(input bit wr, input logic [1:0] reg_idx, input logic [31:0] wdata,
                            output logic [31:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {reg_idx, 2'b00};
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  // Write a register and read it back
  task automatic program_register(input logic [1:0] reg_idx, input logic [31:0] value);
    logic [31:0] rdata;
    apb_access(1'b1, reg_idx, value, rdata);
    apb_access(1'b0, reg_idx, '0, rdata);
    if (rdata !== value) begin
      $display("%0t: register %0d readback expected %h actual %h", $time, reg_idx, value,
               rdata);
      fail_count++;
    end
  endtask

  task automatic set_pool_config(input logic [ADDR_W-1:0] base, input logic [CNT_W-1:0] count,
                                 input logic [MARGIN_W-1:0] margin);
    cfg_base   = base;
    cfg_count  = count;
    cfg_margin = margin;
    program_register(REG_POOL_BASE, base);
    program_register(REG_ENTRY_COUNT, 32'(count));
    program_register(REG_LOW_MARGIN, 32'(margin));
  endtask

  // Drop start and hold until every predicted beat has arrived
  task automatic drain_replies();
    start <= 1'b0;
    @(posedge clk_i);
    while (pool_reply_q.size() != 0) @(posedge clk_i);
  endtask

  // Hold a command until accepted, then queue its reply
  task automatic issue_command(input logic [1:0] cmd, input logic [ADDR_W-1:0] addr,
                               input bit typed, input pool_reply_t typed_reply,
                               output pool_reply_t predicted);
    start           <= 1'b1;
    command_i       <= cmd;
    entry_address_i <= addr;
    do @(posedge clk_i); while (busy !== 1'b0);
    predicted = compute_pool_reply(cmd, addr);
    pool_reply_q.push_back(typed ? typed_reply : predicted);
    if (cmd == CMD_INIT && predicted.status == STS_OK) held_q.delete();
    if (cmd == CMD_ALLOC && predicted.status == STS_OK) held_q.push_back(predicted.addr);
  endtask

  task automatic idle_sender();
    if (idle_on && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
    end
  endtask

  initial begin
    pool_reply_t got;
    stim_row_t row;
    logic [ADDR_W-1:0] base;
    logic [ADDR_W-1:0] addr;
    logic [ADDR_W-1:0] last_freed;
    logic [CNT_W-1:0] count;
    logic [MARGIN_W-1:0] margin;
    logic [1:0] cmd;
    int phase_len;
    int alloc_pct;
    int r;
    int pick;

    for (int i = 0; i < POOL_DEPTH; i++) link_mem[i] = '0;
    last_freed = '0;

    // Commands before any init
    row_chk(CMD_ALLOC, 32'h0, STS_DEPLETED, 32'h0, 0, 1'b0);
    row_chk(CMD_FREE, 32'h40, STS_DEPLETED, 32'h0, 0, 1'b0);
    row_chk(CMD_FREE, 32'h0, STS_OK, 32'h0, 0, 1'b0);
    row_chk(CMD_UNUSED, 32'hFFFF_FFFF, STS_OK, 32'h0, 0, 1'b0);
    // Rejected configurations: misaligned, past 2^32, too few, too many
    row_cfg(32'h20, 64, 10);
    row_chk(CMD_INIT, 32'h0, STS_BAD_CFG, 32'h0, 0, 1'b0);
    row_cfg(32'hFFFF_FFC0, 64, 10);
    row_chk(CMD_INIT, 32'h0, STS_BAD_CFG, 32'h0, 0, 1'b0);
    row_cfg(32'h1000, 1, 10);
    row_chk(CMD_INIT, 32'h0, STS_BAD_CFG, 32'h0, 0, 1'b0);
    row_cfg(32'h1000, 65, 10);
    row_chk(CMD_INIT, 32'h0, STS_BAD_CFG, 32'h0, 0, 1'b0);
    row_cfg(32'h1000, 127, 63);
    row_chk(CMD_INIT, 32'h0, STS_BAD_CFG, 32'h0, 0, 1'b0);
    // Smallest pool: drain it, bad frees, then a double free
    row_cfg(32'h1000, 2, 63);
    row_chk(CMD_INIT, 32'h0, STS_OK, 32'h0, 2, 1'b0);
    row_chk(CMD_ALLOC, 32'h0, STS_OK, 32'h1000, 1, 1'b0);
    row_chk(CMD_ALLOC, 32'h0, STS_OK, 32'h1040, 0, 1'b0);
    row_chk(CMD_ALLOC, 32'h0, STS_DEPLETED, 32'h0, 0, 1'b0);
    row_chk(CMD_FREE, 32'h1080, STS_BAD_ADDR, 32'h0, 0, 1'b0);
    row_chk(CMD_FREE, 32'h1001, STS_BAD_ADDR, 32'h0, 0, 1'b0);
    row_chk(CMD_FREE, 32'h0FC0, STS_BAD_ADDR, 32'h0, 0, 1'b0);
    row_chk(CMD_FREE, 32'h1040, STS_OK, 32'h0, 1, 1'b0);
    row_chk(CMD_FREE, 32'h1040, STS_OK, 32'h0, 2, 1'b0);
    row_cmd(CMD_ALLOC, 32'h0);
    // Pool ending exactly at 2^32, no margin
    row_cfg(32'hFFFF_F000, 64, 0);
    row_chk(CMD_INIT, 32'h0, STS_OK, 32'h0, 64, 1'b0);
    row_chk(CMD_ALLOC, 32'h0, STS_OK, 32'hFFFF_F000, 63, 1'b0);
    row_cmd(CMD_FREE, 32'hFFFF_FFC0);
    // Low warning at entry 2, cleared by init
    row_cfg(32'h0, 64, 62);
    row_chk(CMD_INIT, 32'h0, STS_OK, 32'h0, 64, 1'b0);
    row_chk(CMD_ALLOC, 32'h0, STS_OK, 32'h0, 63, 1'b0);
    row_chk(CMD_ALLOC, 32'h0, STS_OK, 32'h40, 62, 1'b1);
    row_chk(CMD_INIT, 32'h0, STS_OK, 32'h0, 64, 1'b0);

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Walk the directed rows
    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      if (row.is_cfg) begin
        drain_replies();
        set_pool_config(row.base, row.count, row.margin);
      end else begin
        issue_command(row.cmd, row.addr, row.typed, row.reply, got);
        idle_sender();
      end
    end

    // Random phases: new config, init, then mostly alloc/free traffic
    while (random_sent < RANDOM_ITEMS) begin
      drain_replies();
      idle_on = ($urandom_range(0, 3) != 0) && (random_sent < RANDOM_ITEMS - TAIL_ITEMS);
      count  = CNT_W'($urandom_range(MIN_ENTRIES, POOL_DEPTH));
      margin = MARGIN_W'($urandom_range(0, 63));
      base   = $urandom & ~ADDR_W'(ENTRY_BYTES - 1);
      case ($urandom_range(0, 9))
        0: begin
          base   = '0;
          count  = CNT_W'(POOL_DEPTH);
          margin = '0;
        end
        1: base = '0 - ADDR_W'(count * ENTRY_BYTES);
        2: count = CNT_W'(MIN_ENTRIES);
        3: begin
          count  = CNT_W'(POOL_DEPTH);
          margin = MARGIN_W'(63);
        end
        4: begin
          if ($urandom_range(0, 1)) base = base | ADDR_W'($urandom_range(1, ENTRY_BYTES - 1));
          else count = ($urandom_range(0, 1)) ? CNT_W'($urandom_range(0, 1))
                                              : CNT_W'($urandom_range(POOL_DEPTH + 1, 127));
        end
        default: ;
      endcase
      set_pool_config(base, count, margin);
      issue_command(CMD_INIT, '0, 1'b0, '0, got);
      random_sent++;
      phase_len = $urandom_range(60, 160);
      alloc_pct = $urandom_range(30, 70);
      for (int k = 0; k < phase_len && random_sent < RANDOM_ITEMS; k++) begin
        if (random_sent >= RANDOM_ITEMS - TAIL_ITEMS) idle_on = 1'b0;
        r = $urandom_range(0, 99);
        cmd  = CMD_ALLOC;
        addr = $urandom;
        if (r >= alloc_pct) begin
          cmd = CMD_FREE;
          if (r < 85 && held_q.size() != 0) begin
            pick = $urandom_range(0, held_q.size() - 1);
            addr = held_q[pick];
            held_q.delete(pick);
          end else if (r < 85) begin
            cmd = CMD_ALLOC;
          end else if (r < 90) begin
            case ($urandom_range(0, 3))
              0: addr = $urandom;
              1: addr = cfg_base + ADDR_W'($urandom_range(1, ENTRY_BYTES - 1));
              2: addr = cfg_base + ADDR_W'((cfg_count + $urandom_range(0, 8)) * ENTRY_BYTES);
              default: addr = cfg_base - ADDR_W'($urandom_range(1, 4) * ENTRY_BYTES);
            endcase
          end else if (r < 93) begin
            addr = '0;
          end else if (r < 95) begin
            cmd = CMD_UNUSED;
          end else if (r < 97) begin
            cmd = CMD_INIT;
          end else begin
            addr = last_freed;
          end
        end
        if (cmd == CMD_FREE) last_freed = addr;
        issue_command(cmd, addr, 1'b0, '0, got);
        random_sent++;
        // Now and then let the pool settle completely mid-phase, never in the tail
        if (random_sent < RANDOM_ITEMS - TAIL_ITEMS && $urandom_range(0, 99) == 0) begin
          drain_replies();
        end else begin
          idle_sender();
        end
      end
    end

    drain_replies();
    repeat (POOL_DEPTH + 4) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/cafl_pkg.sv
rtl/cafl_regs.sv
rtl/cafl_ctrl.sv
rtl/cafl_dp.sv
rtl/context_area_free_list_allocator.sv
tb/sv/testbench.sv
